// ===== rtl/core/spsm_pkg.sv =====
// Package for the slotted page space manager: field widths, layout defaults,
// compaction terms, operation and status codes, controller state and entry types.
// No dependencies; imported by slotted_page_space_manager.
package spsm_pkg;

    // Fixed field widths of the request and response channels
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 13;
    localparam int IDX_W     = 10;
    localparam int GIVEN_W   = 9;
    localparam int COUNT_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int PAGE_NO_W = 32;
    localparam int ROW_W     = 64;

    // Default page layout
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int ENTRY_BYTES_DEF  = 8;
    localparam int MAX_SLOTS_DEF    = 512;

    // Compaction advice: dead * 5 > used * 2 (dead share above 40 percent)
    localparam int COMPACT_DEAD_MUL = 5;
    localparam int COMPACT_USED_MUL = 2;
    localparam int COMPACT_W        = BYTE_W + 3;

    typedef enum logic [OP_W-1:0] {
        OP_RESET  = 2'd0,
        OP_INSERT = 2'd1,
        OP_GET    = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_BUFFER = 2'd3
    } status_t;

    typedef enum logic {
        SPM_IDLE = 1'b0,
        SPM_EXEC = 1'b1
    } spm_state_t;

    // One directory entry: tuple offset and tuple length
    typedef struct packed {
        logic [BYTE_W-1:0] offset;
        logic [BYTE_W-1:0] length;
    } dir_entry_t;

endpackage

// ===== rtl/core/slotted_page_space_manager.sv =====
// Slotted page space manager: slot directory in a synchronous memory plus
// page layout counters. Depends on spsm_pkg.
//
//  channel   signals                              direction
//  -------   -----------------------------------  ---------
//  request   req_valid/req_stall, operation ...   in
//  response  rsp_valid/rsp_stall, status ...      out
//  config    cfg_wr_en/cfg_wr_data (page number)  in
//
// In each operation the transfer cycle issues the directory read; the EXEC
// state then uses the registered read data, writes back a changed entry and
// loads the response register. A new request is taken while a response still
// waits; execution holds while the response register is full and stalled.
// Reset (rst_n, asynchronous) gives the empty page layout at once; the
// directory needs no clearing pass.
module slotted_page_space_manager
#(
    parameter int PAGE_BYTES   = spsm_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = spsm_pkg::HEADER_BYTES_DEF,
    parameter int ENTRY_BYTES  = spsm_pkg::ENTRY_BYTES_DEF,
    parameter int MAX_SLOTS    = spsm_pkg::MAX_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [spsm_pkg::PAGE_NO_W-1:0] cfg_wr_data,
    // request
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [spsm_pkg::OP_W-1:0]      operation,
    input  logic [spsm_pkg::BYTE_W-1:0]    tuple_length,
    input  logic [spsm_pkg::IDX_W-1:0]     slot_number,
    input  logic [spsm_pkg::BYTE_W-1:0]    buffer_size,
    // response
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [spsm_pkg::STATUS_W-1:0]  status,
    output logic [spsm_pkg::GIVEN_W-1:0]   given_slot,
    output logic [spsm_pkg::BYTE_W-1:0]    tuple_offset,
    output logic [spsm_pkg::BYTE_W-1:0]    stored_length,
    output logic [spsm_pkg::ROW_W-1:0]     row_address,
    output logic [spsm_pkg::BYTE_W-1:0]    free_bytes,
    output logic [spsm_pkg::COUNT_W-1:0]   entry_count,
    output logic                           compact_advised,
    output logic                           slot_alive
);

    import spsm_pkg::*;

    localparam int SLOT_AW   = $clog2(MAX_SLOTS);
    localparam int USED_W    = $clog2(MAX_SLOTS + 1);
    localparam int IDX_CMP_W = ((USED_W > IDX_W) ? USED_W : IDX_W) + 1;

    // Directory memory
    dir_entry_t dir_mem [MAX_SLOTS];

    // Control and layout state
    spm_state_t state_reg, state_next;
    logic [PAGE_NO_W-1:0] page_no_reg;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [BYTE_W-1:0]    dir_end_reg, dir_end_next;
    logic [BYTE_W-1:0]    tas_reg, tas_next;
    logic [BYTE_W-1:0]    live_reg, live_next;
    logic                 rsp_valid_reg;

    // Captured request
    op_t               op_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] buf_reg;
    dir_entry_t        rd_data_reg;

    // Response registers
    status_t              status_reg;
    logic [GIVEN_W-1:0]   given_reg;
    logic [BYTE_W-1:0]    offs_reg;
    logic [BYTE_W-1:0]    slen_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [BYTE_W-1:0]    free_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 compact_reg;
    logic                 alive_reg;

    // Handshake and execution strobes
    logic req_xfer;
    logic rsp_xfer;
    logic exec_fire;

    // Datapath results
    status_t           status_c;
    logic [GIVEN_W-1:0] given_c;
    logic [BYTE_W-1:0] offs_c;
    logic [BYTE_W-1:0] slen_c;
    logic [ROW_W-1:0]  row_c;
    logic              alive_c;
    logic [BYTE_W-1:0] free_c;
    logic              compact_c;
    logic              wr_en_c;
    logic [SLOT_AW-1:0] wr_addr_c;
    dir_entry_t        wr_data_c;

    logic [BYTE_W-1:0] ins_start;
    logic [BYTE_W:0]   ins_new_end;
    logic              ins_full;
    logic              idx_bad;
    logic [BYTE_W-1:0] gap;
    logic [BYTE_W-1:0] used_bytes;
    logic [BYTE_W-1:0] dead_bytes;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SPM_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = SPM_EXEC;
                end
            end
            SPM_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = SPM_IDLE;
                end
            end
            default: state_next = SPM_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        req_stall = (state_reg != SPM_IDLE);
        exec_fire = (state_reg == SPM_EXEC) && (!rsp_valid_reg || !rsp_stall);
    end

    assign req_xfer = req_valid && !req_stall;
    assign rsp_xfer = rsp_valid_reg && !rsp_stall;

    // Execute one operation on the captured request and read data
    always_comb
    begin
        status_c     = ST_OK;
        given_c      = '0;
        offs_c       = '0;
        slen_c       = '0;
        row_c        = '0;
        alive_c      = 1'b0;
        wr_en_c      = 1'b0;
        wr_addr_c    = idx_reg[SLOT_AW-1:0];
        wr_data_c    = '0;
        used_next    = used_reg;
        dir_end_next = dir_end_reg;
        tas_next     = tas_reg;
        live_next    = live_reg;

        ins_start   = tas_reg - len_reg;
        ins_new_end = {1'b0, dir_end_reg} + (BYTE_W+1)'(ENTRY_BYTES);
        ins_full    = (used_reg >= USED_W'(MAX_SLOTS)) || (len_reg > tas_reg)
                      || ({1'b0, ins_start} < ins_new_end);
        idx_bad     = (IDX_CMP_W'(idx_reg) >= IDX_CMP_W'(used_reg))
                      || (IDX_CMP_W'(idx_reg) >= IDX_CMP_W'(MAX_SLOTS));

        unique case (op_reg)
            OP_RESET:
            begin
                used_next    = '0;
                dir_end_next = BYTE_W'(HEADER_BYTES);
                tas_next     = BYTE_W'(PAGE_BYTES);
                live_next    = '0;
            end
            OP_INSERT:
            begin
                if (ins_full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    given_c          = GIVEN_W'(used_reg);
                    offs_c           = ins_start;
                    slen_c           = len_reg;
                    row_c            = {page_no_reg, (ROW_W-PAGE_NO_W)'(used_reg)};
                    alive_c          = (len_reg != '0);
                    wr_en_c          = 1'b1;
                    wr_addr_c        = used_reg[SLOT_AW-1:0];
                    wr_data_c.offset = ins_start;
                    wr_data_c.length = len_reg;
                    used_next        = used_reg + USED_W'(1);
                    dir_end_next     = ins_new_end[BYTE_W-1:0];
                    tas_next         = ins_start;
                    live_next        = live_reg + len_reg;
                end
            end
            OP_GET:
            begin
                if (idx_bad)
                begin
                    status_c = ST_RANGE;
                end
                else if (rd_data_reg.length != '0)
                begin
                    offs_c  = rd_data_reg.offset;
                    slen_c  = rd_data_reg.length;
                    alive_c = 1'b1;
                    if (rd_data_reg.length > buf_reg)
                    begin
                        status_c = ST_BUFFER;
                    end
                end
            end
            OP_DELETE:
            begin
                if (idx_bad)
                begin
                    status_c = ST_RANGE;
                end
                else if (rd_data_reg.length != '0)
                begin
                    wr_en_c   = 1'b1;
                    live_next = (live_reg >= rd_data_reg.length)
                                ? live_reg - rd_data_reg.length : '0;
                end
            end
            default: status_c = ST_OK;
        endcase

        // Free space after the operation
        gap = tas_next - dir_end_next;
        if ((tas_next < dir_end_next) || (gap < BYTE_W'(ENTRY_BYTES)))
        begin
            free_c = '0;
        end
        else
        begin
            free_c = gap - BYTE_W'(ENTRY_BYTES);
        end

        // Compaction advice after the operation
        used_bytes = BYTE_W'(PAGE_BYTES) - tas_next;
        dead_bytes = (live_next <= used_bytes) ? used_bytes - live_next : '0;
        if (tas_next >= BYTE_W'(PAGE_BYTES))
        begin
            compact_c = 1'b0;
        end
        else
        begin
            compact_c = (COMPACT_W'(dead_bytes) * COMPACT_W'(COMPACT_DEAD_MUL))
                        > (COMPACT_W'(used_bytes) * COMPACT_W'(COMPACT_USED_MUL));
        end
    end

    // Directory memory: read on request transfer, write back on execution
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            rd_data_reg <= dir_mem[slot_number[SLOT_AW-1:0]];
        end
        if (exec_fire && wr_en_c)
        begin
            dir_mem[wr_addr_c] <= wr_data_c;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg  <= op_t'(operation);
            len_reg <= tuple_length;
            idx_reg <= slot_number;
            buf_reg <= buffer_size;
        end
    end

    // Load the response payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg  <= status_c;
            given_reg   <= given_c;
            offs_reg    <= offs_c;
            slen_reg    <= slen_c;
            row_reg     <= row_c;
            free_reg    <= free_c;
            count_reg   <= COUNT_W'(used_next);
            compact_reg <= compact_c;
            alive_reg   <= alive_c;
        end
    end

    // Control and layout state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SPM_IDLE;
            page_no_reg   <= '0;
            used_reg      <= '0;
            dir_end_reg   <= BYTE_W'(HEADER_BYTES);
            tas_reg       <= BYTE_W'(PAGE_BYTES);
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                page_no_reg <= cfg_wr_data;
            end
            if (exec_fire)
            begin
                used_reg    <= used_next;
                dir_end_reg <= dir_end_next;
                tas_reg     <= tas_next;
                live_reg    <= live_next;
            end
            // Hold the response until its transfer, refill on execution
            if (exec_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign given_slot      = given_reg;
    assign tuple_offset    = offs_reg;
    assign stored_length   = slen_reg;
    assign row_address     = row_reg;
    assign free_bytes      = free_reg;
    assign entry_count     = count_reg;
    assign compact_advised = compact_reg;
    assign slot_alive      = alive_reg;

endmodule

// ===== sim/slotted_page_space_manager_tb.sv =====
// Testbench for slotted_page_space_manager: directed and random page operations
// with a tracking model of the page layout that checks every response transfer.
// Depends on spsm_pkg and the slotted_page_space_manager RTL.
module slotted_page_space_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spsm_pkg::*;

    localparam int PAGE_SPAN   = PAGE_BYTES_DEF;
    localparam int HEADER_SIZE = HEADER_BYTES_DEF;
    localparam int ENTRY_SIZE  = ENTRY_BYTES_DEF;
    localparam int SLOT_LIMIT  = MAX_SLOTS_DEF;
    localparam int LONG_HOLD   = 80;

    // One response of the block
    typedef struct {
        status_t              status;
        logic [GIVEN_W-1:0]   given;
        logic [BYTE_W-1:0]    offset;
        logic [BYTE_W-1:0]    length;
        logic [ROW_W-1:0]     row;
        logic [BYTE_W-1:0]    free;
        logic [COUNT_W-1:0]   count;
        logic                 compact;
        logic                 alive;
    } page_reply_t;

    // Tracks the page layout and holds the replies still owed by the block
    class page_layout_tracker;
        logic [PAGE_NO_W-1:0] page_no;
        dir_entry_t           slot_table [SLOT_LIMIT];
        int unsigned          slots_used;
        int unsigned          dir_end;
        int unsigned          tuple_start;
        int unsigned          live_bytes;
        page_reply_t          awaited [$];
        int                   errors;

        function new();
            page_no = '0;
            errors  = 0;
            clear_layout();
        endfunction

        function void clear_layout();
            slots_used  = 0;
            dir_end     = HEADER_SIZE;
            tuple_start = PAGE_SPAN;
            live_bytes  = 0;
        endfunction

        function int unsigned free_space();
            int unsigned gap;
            if (tuple_start < dir_end)
                return 0;
            gap = tuple_start - dir_end;
            if (gap < ENTRY_SIZE)
                return 0;
            return gap - ENTRY_SIZE;
        endfunction

        function bit compact_hint();
            int unsigned used;
            int unsigned dead;
            if (tuple_start >= PAGE_SPAN)
                return 1'b0;
            used = PAGE_SPAN - tuple_start;
            dead = (live_bytes <= used) ? used - live_bytes : 0;
            return (dead * COMPACT_DEAD_MUL > used * COMPACT_USED_MUL);
        endfunction

        // Work out the reply of one accepted request and advance the layout
        function void note_request(op_t op, logic [BYTE_W-1:0] len_in,
                                   logic [IDX_W-1:0] idx_in, logic [BYTE_W-1:0] bufsz_in);
            page_reply_t r;
            int unsigned len;
            int unsigned idx;
            int unsigned bufsz;
            int unsigned start;
            dir_entry_t  e;
            len       = len_in;
            idx       = idx_in;
            bufsz     = bufsz_in;
            r.status  = ST_OK;
            r.given   = '0;
            r.offset  = '0;
            r.length  = '0;
            r.row     = '0;
            r.alive   = 1'b0;
            case (op)
                OP_RESET:
                begin
                    clear_layout();
                end
                OP_INSERT:
                begin
                    if (slots_used >= SLOT_LIMIT || len > tuple_start ||
                        tuple_start - len < dir_end + ENTRY_SIZE)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        start = tuple_start - len;
                        slot_table[slots_used].offset = BYTE_W'(start);
                        slot_table[slots_used].length = BYTE_W'(len);
                        r.given  = GIVEN_W'(slots_used);
                        r.row    = {page_no, 32'(slots_used)};
                        r.offset = BYTE_W'(start);
                        r.length = BYTE_W'(len);
                        r.alive  = (len != 0);
                        slots_used++;
                        dir_end     += ENTRY_SIZE;
                        tuple_start = start;
                        live_bytes  += len;
                    end
                end
                default:
                begin
                    if (idx >= slots_used || idx >= SLOT_LIMIT)
                    begin
                        r.status = ST_RANGE;
                    end
                    else if (op == OP_GET)
                    begin
                        e = slot_table[idx];
                        if (e.length != 0)
                        begin
                            r.offset = e.offset;
                            r.length = e.length;
                            r.alive  = 1'b1;
                            if (e.length > bufsz)
                                r.status = ST_BUFFER;
                        end
                    end
                    else
                    begin
                        // drop a live tuple; a dead slot stays as it is
                        e = slot_table[idx];
                        if (e.length != 0)
                        begin
                            live_bytes = (live_bytes >= e.length) ? live_bytes - e.length : 0;
                            slot_table[idx] = '0;
                        end
                    end
                end
            endcase
            r.free    = BYTE_W'(free_space());
            r.count   = COUNT_W'(slots_used);
            r.compact = compact_hint();
            awaited.push_back(r);
        endfunction

        function void field_check(string name, logic [ROW_W-1:0] want, logic [ROW_W-1:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        // Compare one response transfer with the oldest reply owed
        function void check_reply(page_reply_t got);
            page_reply_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: response transfer with no request outstanding", $time);
                errors++;
                return;
            end
            want = awaited.pop_front();
            field_check("status",          want.status,  got.status);
            field_check("given_slot",      want.given,   got.given);
            field_check("tuple_offset",    want.offset,  got.offset);
            field_check("stored_length",   want.length,  got.length);
            field_check("row_address",     want.row,     got.row);
            field_check("free_bytes",      want.free,    got.free);
            field_check("entry_count",     want.count,   got.count);
            field_check("compact_advised", want.compact, got.compact);
            field_check("slot_alive",      want.alive,   got.alive);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [PAGE_NO_W-1:0]   cfg_wr_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [OP_W-1:0]        operation = '0;
    logic [BYTE_W-1:0]      tuple_length = '0;
    logic [IDX_W-1:0]       slot_number = '0;
    logic [BYTE_W-1:0]      buffer_size = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [GIVEN_W-1:0]     given_slot;
    logic [BYTE_W-1:0]      tuple_offset;
    logic [BYTE_W-1:0]      stored_length;
    logic [ROW_W-1:0]       row_address;
    logic [BYTE_W-1:0]      free_bytes;
    logic [COUNT_W-1:0]     entry_count;
    logic                   compact_advised;
    logic                   slot_alive;

    page_layout_tracker tracker = new();
    int                 rsp_stall_pct = 0;
    bit                 long_hold_pending = 1'b0;

    slotted_page_space_manager dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .operation       (operation),
        .tuple_length    (tuple_length),
        .slot_number     (slot_number),
        .buffer_size     (buffer_size),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .given_slot      (given_slot),
        .tuple_offset    (tuple_offset),
        .stored_length   (stored_length),
        .row_address     (row_address),
        .free_bytes      (free_bytes),
        .entry_count     (entry_count),
        .compact_advised (compact_advised),
        .slot_alive      (slot_alive)
    );

    // 10 ns clock
    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // Check every response transfer
    always @(posedge clk)
    begin
        page_reply_t got;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            got.status  = status_t'(status);
            got.given   = given_slot;
            got.offset  = tuple_offset;
            got.length  = stored_length;
            got.row     = row_address;
            got.free    = free_bytes;
            got.count   = entry_count;
            got.compact = compact_advised;
            got.alive   = slot_alive;
            tracker.check_reply(got);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct)
                    stall_left = $urandom_range(9, 1);
            end
        end
    end

    // Give up on a hung run
    initial
    begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one request after an optional gap and hold it until the transfer
    task automatic issue(input op_t op, input logic [BYTE_W-1:0] len,
                         input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] bufsz,
                         input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid    <= 1'b1;
        operation    <= op;
        tuple_length <= len;
        slot_number  <= idx;
        buffer_size  <= bufsz;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        tracker.note_request(op, len, idx, bufsz);
    endtask

    // Stop offering and wait until every owed reply has arrived
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the page number register; only called while the block is idle
    task automatic set_page_number(input logic [PAGE_NO_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.page_no = value;
    endtask

    // Random operations: inserts at the given percentage, mostly in-range accesses, with noise
    task automatic run_phase(input int count, input int ins_pct, input int len_cap,
                             input int gap_pct, input int stall_pct);
        op_t               op;
        logic [BYTE_W-1:0] len;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] bufsz;
        int                roll;
        int                gap;
        bit                near_full;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            near_full = tracker.free_space() < 48;
            if ((near_full && $urandom_range(99) < 25) || $urandom_range(499) == 0)
            begin
                op = OP_RESET;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < ins_pct)
                    op = OP_INSERT;
                else if (roll < ins_pct + (100 - ins_pct) / 2)
                    op = OP_GET;
                else
                    op = OP_DELETE;
            end

            roll = $urandom_range(99);
            if (op != OP_INSERT)
                len = BYTE_W'($urandom_range(8191));
            else if (roll < 70)
                len = BYTE_W'($urandom_range(len_cap));
            else if (roll < 85)
                len = BYTE_W'($urandom_range(400));
            else if (roll < 95)
                len = BYTE_W'($urandom_range(4096));
            else
                len = BYTE_W'($urandom_range(8191));

            if (tracker.slots_used > 0 && $urandom_range(99) < 85)
                idx = IDX_W'($urandom_range(tracker.slots_used - 1));
            else
                idx = IDX_W'($urandom_range(1023));

            if ($urandom_range(99) < 50)
                bufsz = BYTE_W'($urandom_range(64));
            else
                bufsz = BYTE_W'($urandom_range(8191));

            gap = ($urandom_range(99) < gap_pct) ? $urandom_range(9, 1) : 0;
            issue(op, len, idx, bufsz, gap);
        end
        drain();
    endtask

    initial
    begin
        // hold reset, then release it away from the clock edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty page, zero-length slot, bad index, short buffer,
        // dead slots, full page, page reset and compaction advice
        set_page_number(32'hFFFF_FFFF);
        issue(OP_GET,    0,    0,    0,    0);
        issue(OP_DELETE, 0,    0,    0,    0);
        issue(OP_INSERT, 0,    0,    0,    0);
        issue(OP_INSERT, 100,  0,    0,    0);
        issue(OP_GET,    0,    1,    100,  0);
        issue(OP_GET,    0,    1,    99,   0);
        issue(OP_GET,    0,    0,    8191, 0);
        issue(OP_GET,    0,    1023, 8191, 0);
        issue(OP_GET,    0,    2,    8191, 0);
        issue(OP_DELETE, 0,    1,    0,    0);
        issue(OP_DELETE, 0,    1,    0,    0);
        issue(OP_GET,    0,    1,    0,    0);
        issue(OP_INSERT, 8191, 0,    0,    0);
        issue(OP_INSERT, 4096, 0,    0,    0);
        issue(OP_INSERT, 3957, 0,    0,    0);
        issue(OP_INSERT, 3956, 0,    0,    0);
        issue(OP_INSERT, 0,    0,    0,    0);
        issue(OP_RESET,  8191, 1023, 8191, 0);
        issue(OP_GET,    0,    0,    8191, 0);
        issue(OP_INSERT, 4072, 0,    0,    0);
        issue(OP_DELETE, 0,    0,    0,    0);
        issue(OP_INSERT, 0,    0,    0,    0);
        issue(OP_RESET,  0,    0,    0,    0);
        issue(OP_INSERT, 1,    0,    0,    0);
        issue(OP_GET,    0,    0,    1,    0);
        drain();

        // Random phases under several page numbers and idling patterns
        set_page_number(32'h0000_0000);
        run_phase(300, 45, 40, 15, 15);

        set_page_number($urandom());
        run_phase(400, 75, 2, 0, 0);

        // receiver holds off while the sender keeps offering
        set_page_number(32'h8000_0000 | $urandom());
        long_hold_pending = 1'b1;
        run_phase(300, 45, 400, 0, 10);

        set_page_number($urandom());
        run_phase(350, 50, 40, 40, 40);

        // last part without idling
        set_page_number(32'h0000_0001);
        run_phase(350, 50, 40, 0, 0);

        repeat (10) @(posedge clk);
        if (tracker.awaited.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, tracker.awaited.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/spsm_pkg.sv
rtl/core/slotted_page_space_manager.sv
sim/slotted_page_space_manager_tb.sv
